// ----- hdl/wwtl_pkg.sv -----
// ----------------------------------------------------------------------------
// wwtl_pkg
// Shared types, character codes and helpers for the whole-word text locator.
// ----------------------------------------------------------------------------
package wwtl_pkg;

   localparam int KEY_TEXT_WORDS = 4;
   localparam int KEY_TEXT_BYTES = 32;
   localparam int KEY_WORD_BITS  = 64;
   localparam int KEY_LEN_BITS   = 6;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int LINE_BITS      = 24;
   localparam int OUT_COL_BITS   = 16;
   localparam int SPAN_BITS      = 7;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 40;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   localparam logic [LINE_BITS-1:0]    LINE_SAT    = '1;
   localparam logic [OUT_COL_BITS-1:0] OUT_COL_SAT = '1;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_KEY_TEXT_0 = 3'd0,
      REG_KEY_TEXT_1 = 3'd1,
      REG_KEY_TEXT_2 = 3'd2,
      REG_KEY_TEXT_3 = 3'd3,
      REG_KEY_LENGTH = 3'd4,
      REG_KEY_FORM   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                 valid;
      logic [SPAN_BITS-1:0] span_m1;
   } key_shape_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

endpackage

// ----- hdl/wwtl_key_table.sv -----
// ----------------------------------------------------------------------------
// wwtl_key_table
// Key registers and the key laid out against the byte history, newest first.
// ----------------------------------------------------------------------------
module wwtl_key_table #(
   parameter int KEY_MAX = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_tvalid,
   input  logic [wwtl_pkg::CSR_ADDR_BITS-1:0]         csr_addr,
   input  logic [wwtl_pkg::KEY_WORD_BITS-1:0]         csr_wdata,
   output logic [KEY_MAX-1:0][7:0]                    key_chars,
   output logic [KEY_MAX-1:0]                         key_care,
   output logic [KEY_MAX:0]                           key_edge_sel,
   output wwtl_pkg::key_shape_type                    key_shape
);

   logic [wwtl_pkg::KEY_TEXT_WORDS-1:0][wwtl_pkg::KEY_WORD_BITS-1:0] key_text_ff, key_text_in;
   logic [wwtl_pkg::KEY_LEN_BITS-1:0] key_length_ff, key_length_in;
   logic                              key_form_ff, key_form_in;
   logic [wwtl_pkg::KEY_TEXT_BYTES-1:0][7:0] key_bytes;

   logic [KEY_MAX-1:0][7:0]  chars_ff, chars_in;
   logic [KEY_MAX-1:0]       care_ff, care_in;
   logic [KEY_MAX:0]         edge_sel_ff, edge_sel_in;
   wwtl_pkg::key_shape_type  shape_ff, shape_in;

   always_comb begin
      key_text_in   = key_text_ff;
      key_length_in = key_length_ff;
      key_form_in   = key_form_ff;
      if (reset) begin
         key_text_in   = '0;
         key_length_in = wwtl_pkg::KEY_LEN_BITS'(1);
         key_form_in   = 1'b0;
      end else if (csr_tvalid) begin
         case (csr_addr)
            wwtl_pkg::REG_KEY_TEXT_0: key_text_in[0] = csr_wdata;
            wwtl_pkg::REG_KEY_TEXT_1: key_text_in[1] = csr_wdata;
            wwtl_pkg::REG_KEY_TEXT_2: key_text_in[2] = csr_wdata;
            wwtl_pkg::REG_KEY_TEXT_3: key_text_in[3] = csr_wdata;
            wwtl_pkg::REG_KEY_LENGTH:
               key_length_in = csr_wdata[wwtl_pkg::KEY_LEN_BITS-1:0];
            wwtl_pkg::REG_KEY_FORM:   key_form_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign key_bytes = key_text_in;

   always_comb begin
      logic [7:0] len_eff;
      logic [7:0] span;
      logic [7:0] first;
      logic [7:0] idx;
      logic [7:0] raw;
      logic       has_nl;

      len_eff = ({2'b00, key_length_in} > 8'(KEY_MAX)) ? 8'(KEY_MAX)
                                                       : {2'b00, key_length_in};
      if (key_form_in) begin
         span  = (len_eff < 8'd3) ? 8'd0 : len_eff - 8'd2;
         first = 8'd1;
      end else begin
         span  = len_eff;
         first = 8'd0;
      end
      has_nl = 1'b0;
      for (int i = 0; i < KEY_MAX; i++) begin
         idx = first + span - 8'd1 - 8'(i);
         raw = 8'h00;
         if (8'(i) < span && idx < 8'(wwtl_pkg::KEY_TEXT_BYTES)) begin
            raw = key_bytes[idx[4:0]];
         end
         care_in[i] = 8'(i) < span;
         if (care_in[i] && raw == wwtl_pkg::CHAR_NEWLINE) begin
            has_nl = 1'b1;
         end
         chars_in[i] = wwtl_pkg::fold_char(raw);
      end
      for (int i = 0; i <= KEY_MAX; i++) begin
         edge_sel_in[i] = 8'(i) == span;
      end
      shape_in.valid   = (span != 8'd0) && !has_nl;
      shape_in.span_m1 = wwtl_pkg::SPAN_BITS'(span - 8'd1);
   end

   always_ff @(posedge clock) begin
      key_text_ff   <= key_text_in;
      key_length_ff <= key_length_in;
      key_form_ff   <= key_form_in;
      chars_ff      <= chars_in;
      care_ff       <= care_in;
      edge_sel_ff   <= edge_sel_in;
      shape_ff      <= shape_in;
   end

   assign key_chars    = chars_ff;
   assign key_care     = care_ff;
   assign key_edge_sel = edge_sel_ff;
   assign key_shape    = shape_ff;

endmodule

// ----- hdl/whole_word_text_locator_core.sv -----
// ----------------------------------------------------------------------------
// whole_word_text_locator_core
// Case-insensitive whole-word key search over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   csr channel: write the key text words, key length and key form while no
//   item is in flight. csr_tready is always high.
//   req channel: one text byte per item, tlast on the final byte of a text.
//   rsp channel: one item per confirmed match, line and start column.
// Timing:
//   An item enters an input register, is compared against the whole key (a
//   parallel window compare over the byte history) and its result, if any,
//   lands in the output register: rsp_tvalid rises at the edge on which the
//   item that confirms the match leaves the input register.
//   One item per cycle is taken while the output side keeps up.
// Reset:
//   Synchronous. Clears the key to a one-character word of zero, the line
//   counter to 1, the column to 0 and any pending match. The key stays across
//   texts; line, column and history restart after each tlast item.
// Stall:
//   While rsp_tready is low and a result waits, the input register holds and
//   req_tready drops once it is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module whole_word_text_locator_core #(
   parameter int KEY_MAX     = 32,
   parameter int COLUMN_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // tdata: text_byte[7:0]
   input  logic [wwtl_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: match_line[23:0], match_column[39:24]
   output logic [wwtl_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_tvalid,
   output logic                                  csr_tready,
   input  logic [wwtl_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [wwtl_pkg::KEY_WORD_BITS-1:0]    csr_wdata
);

   logic [KEY_MAX-1:0][7:0]  key_chars;
   logic [KEY_MAX-1:0]       key_care;
   logic [KEY_MAX:0]         key_edge_sel;
   wwtl_pkg::key_shape_type  key_shape;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   logic [KEY_MAX-1:0][7:0]             hist_ff, hist_in;
   logic [wwtl_pkg::LINE_BITS-1:0]      line_ff, line_in;
   logic [COLUMN_BITS-1:0]              col_ff, col_in;
   logic                                pend_ff, pend_in;
   logic [wwtl_pkg::OUT_COL_BITS-1:0]   pcol_ff, pcol_in;

   logic                                out_vld_ff, out_vld_in;
   logic [wwtl_pkg::LINE_BITS-1:0]      out_line_ff, out_line_in;
   logic [wwtl_pkg::OUT_COL_BITS-1:0]   out_col_ff, out_col_in;

   logic                                advance;
   logic                                is_nl;
   logic [KEY_MAX:0][7:0]               hist_new;
   logic [KEY_MAX-1:0]                  eq_vec;
   logic [KEY_MAX:0]                    blank_vec;
   logic                                edge_blank;
   logic                                col_sat;
   logic [COLUMN_BITS-1:0]              span_ext;
   logic [COLUMN_BITS-1:0]              start_col;
   logic [COLUMN_BITS+15:0]             start_ext;
   logic [wwtl_pkg::OUT_COL_BITS-1:0]   start_clip;
   logic                                start_ok;
   logic                                win;
   logic                                emit_pend;

   wwtl_key_table #(
      .KEY_MAX(KEY_MAX)
   ) u_key_table (
      .clock        (clock),
      .reset        (reset),
      .csr_tvalid   (csr_tvalid),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .key_chars    (key_chars),
      .key_care     (key_care),
      .key_edge_sel (key_edge_sel),
      .key_shape    (key_shape)
   );

   assign csr_tready = 1'b1;
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      is_nl    = in_byte_ff == wwtl_pkg::CHAR_NEWLINE;
      hist_new = {hist_ff, wwtl_pkg::fold_char(in_byte_ff)};
      for (int i = 0; i < KEY_MAX; i++) begin
         eq_vec[i] = !key_care[i] || (hist_new[i] == key_chars[i]);
      end
      for (int i = 0; i <= KEY_MAX; i++) begin
         blank_vec[i] = wwtl_pkg::is_blank(hist_new[i]);
      end
      edge_blank = |(blank_vec & key_edge_sel);
      col_sat    = col_ff == '1;
      span_ext   = COLUMN_BITS'(key_shape.span_m1);
      start_col  = col_sat ? '1 : col_ff - span_ext;
      start_ok   = col_sat ? edge_blank : ((start_col == '0) || edge_blank);
      win        = !is_nl && key_shape.valid && (col_ff >= span_ext) && (&eq_vec)
                   && start_ok;
      start_ext  = (COLUMN_BITS+16)'(start_col);
      start_clip = (start_ext > (COLUMN_BITS+16)'(wwtl_pkg::OUT_COL_SAT))
                   ? wwtl_pkg::OUT_COL_SAT : start_ext[wwtl_pkg::OUT_COL_BITS-1:0];
      emit_pend  = pend_ff && (wwtl_pkg::is_blank(in_byte_ff) || is_nl);
   end

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      in_last_in = in_last_ff;
      if (req_tready) begin
         in_vld_in  = req_tvalid;
         in_byte_in = req_tdata[7:0];
         in_last_in = req_tlast;
      end

      hist_in     = hist_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      pend_in     = pend_ff;
      pcol_in     = pcol_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_line_in = out_line_ff;
      out_col_in  = out_col_ff;

      if (advance) begin
         hist_in = hist_new[KEY_MAX-1:0];
         pend_in = 1'b0;
         if (emit_pend) begin
            out_vld_in  = 1'b1;
            out_line_in = line_ff;
            out_col_in  = pcol_ff;
         end
         if (is_nl) begin
            if (line_ff != wwtl_pkg::LINE_SAT) begin
               line_in = line_ff + wwtl_pkg::LINE_BITS'(1);
            end
            col_in = '0;
         end else begin
            if (win) begin
               if (in_last_ff) begin
                  if (!emit_pend) begin
                     out_vld_in  = 1'b1;
                     out_line_in = line_ff;
                     out_col_in  = start_clip;
                  end
               end else begin
                  pend_in = 1'b1;
                  pcol_in = start_clip;
               end
            end
            if (!col_sat) begin
               col_in = col_ff + COLUMN_BITS'(1);
            end
         end
         if (in_last_ff) begin
            hist_in = '0;
            line_in = wwtl_pkg::LINE_BITS'(1);
            col_in  = '0;
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         hist_ff    <= '0;
         line_ff    <= wwtl_pkg::LINE_BITS'(1);
         col_ff     <= '0;
         pend_ff    <= 1'b0;
         pcol_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         hist_ff    <= hist_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
         pend_ff    <= pend_in;
         pcol_ff    <= pcol_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      out_line_ff <= out_line_in;
      out_col_ff  <= out_col_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_col_ff, out_line_ff};

   assert property (@(posedge clock) disable iff (reset) pend_ff |-> col_ff != '0)
      else $error("pending match with column at zero");

   assert property (@(posedge clock) disable iff (reset) line_ff != '0)
      else $error("line counter reached zero");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_vld_ff)
      else $error("accepted item lost from input register");

   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (line_ff == wwtl_pkg::LINE_BITS'(1)) && !pend_ff)
      else $error("text state not cleared after final item");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the whole-word text locator core: drives text bytes
// and key writes, predicts every match (line, start column) in step with each
// accepted item, and checks the result stream in order under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int COL_BITS     = 16;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_BYTES = 1700;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [wwtl_pkg::LINE_BITS-1:0]    line;
      logic [wwtl_pkg::OUT_COL_BITS-1:0] column;
   } match_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic [wwtl_pkg::REQ_DATA_BITS-1:0]  req_tdata;
   logic                                req_tlast;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [wwtl_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic                                csr_tvalid;
   logic                                csr_tready;
   logic [wwtl_pkg::CSR_ADDR_BITS-1:0]  csr_addr;
   logic [wwtl_pkg::KEY_WORD_BITS-1:0]  csr_wdata;

   // key and text state of the predictor
   logic [wwtl_pkg::KEY_WORD_BITS-1:0] key_word [wwtl_pkg::KEY_TEXT_WORDS];
   logic [wwtl_pkg::KEY_LEN_BITS-1:0]  key_len;
   logic                               key_quoted;
   logic [7:0]                         history [wwtl_pkg::KEY_TEXT_BYTES+1];
   logic [wwtl_pkg::LINE_BITS-1:0]     line_count;
   logic [COL_BITS-1:0]                column_count;
   logic                               pending;
   logic [COL_BITS-1:0]                pending_start;

   match_type   expected_matches[$];
   logic [7:0]  text_buf[$];
   int          mismatches  = 0;
   int          bytes_sent  = 0;
   int          idle_cycles = 0;
   int          stall_left  = 0;
   bit          req_gaps_on = 1'b1;
   bit          rsp_gaps_on = 1'b1;

   always #5 clock = ~clock;

   whole_word_text_locator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   function automatic logic [7:0] lowered(input logic [7:0] c);
      if (c >= wwtl_pkg::CHAR_UPPER_A && c <= wwtl_pkg::CHAR_UPPER_Z) begin
         return c + wwtl_pkg::CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic bit is_space_or_tab(input logic [7:0] c);
      return c == wwtl_pkg::CHAR_SPACE || c == wwtl_pkg::CHAR_TAB;
   endfunction

   function automatic void restart_text();
      foreach (history[i]) history[i] = 8'h00;
      line_count    = 1;
      column_count  = '0;
      pending       = 1'b0;
      pending_start = '0;
   endfunction

   // key ends at the newest byte with a word boundary in front of it
   function automatic bit key_ends_here(output logic [COL_BITS-1:0] start);
      int         span;
      int         first;
      int         s;
      logic [7:0] k;
      span  = (key_len > wwtl_pkg::KEY_TEXT_BYTES) ? wwtl_pkg::KEY_TEXT_BYTES
                                                  : int'(key_len);
      first = 0;
      start = '0;
      if (key_quoted) begin
         if (span < 3) return 1'b0;
         span  = span - 2;
         first = 1;
      end
      if (span == 0) return 1'b0;
      if (int'(column_count) < span - 1) return 1'b0;
      for (int j = 0; j < span; j++) begin
         k = key_word[(first + j) / 8][8 * ((first + j) % 8) +: 8];
         if (k == wwtl_pkg::CHAR_NEWLINE || lowered(k) != lowered(history[span - 1 - j]))
            return 1'b0;
      end
      if (column_count == '1) begin
         if (!is_space_or_tab(history[span])) return 1'b0;
         start = '1;
      end else begin
         s = int'(column_count) - (span - 1);
         if (s != 0 && !is_space_or_tab(history[span])) return 1'b0;
         start = s[COL_BITS-1:0];
      end
      return 1'b1;
   endfunction

   function automatic void predict_byte(input logic [7:0] c, input bit is_last);
      match_type           m;
      bit                  reported;
      logic [COL_BITS-1:0] start;
      reported = 1'b0;
      if (pending) begin
         if (is_space_or_tab(c) || c == wwtl_pkg::CHAR_NEWLINE) begin
            m.line   = line_count;
            m.column = pending_start;
            expected_matches.push_back(m);
            reported = 1'b1;
         end
         pending = 1'b0;
      end
      for (int i = wwtl_pkg::KEY_TEXT_BYTES; i > 0; i--) history[i] = history[i-1];
      history[0] = c;
      if (c == wwtl_pkg::CHAR_NEWLINE) begin
         if (line_count != wwtl_pkg::LINE_SAT) line_count++;
         column_count = '0;
      end else begin
         if (key_ends_here(start)) begin
            if (is_last) begin
               if (!reported) begin
                  m.line   = line_count;
                  m.column = start;
                  expected_matches.push_back(m);
               end
            end else begin
               pending       = 1'b1;
               pending_start = start;
            end
         end
         if (column_count != '1) column_count++;
      end
      if (is_last) restart_text();
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin
      logic [wwtl_pkg::LINE_BITS-1:0]    got_line;
      logic [wwtl_pkg::OUT_COL_BITS-1:0] got_column;
      match_type                         want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_line   = rsp_tdata[wwtl_pkg::LINE_BITS-1:0];
         got_column = rsp_tdata[wwtl_pkg::LINE_BITS +: wwtl_pkg::OUT_COL_BITS];
         if (expected_matches.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("unexpected match: line %0d column %0d", got_line, got_column);
            end
         end else begin
            want = expected_matches.pop_front();
            if (got_line !== want.line || got_column !== want.column) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("match mismatch: expected line %0d column %0d, got line %0d column %0d",
                           want.line, want.column, got_line, got_column);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_text_byte(input logic [7:0] c, input bit is_last);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_tdata  <= c;
      req_tlast  <= is_last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      predict_byte(c, is_last);
      bytes_sent++;
   endtask

   function automatic void append_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   // send the buffered text, tlast on its final byte
   task automatic send_buffer();
      int count;
      count = text_buf.size();
      for (int i = 0; i < count; i++) send_text_byte(text_buf[i], i == count - 1);
      text_buf.delete();
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_matches.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all six key registers back to back
   task automatic set_key(input string s,
                          input logic [wwtl_pkg::KEY_LEN_BITS-1:0] len_field,
                          input bit quoted);
      logic [wwtl_pkg::KEY_WORD_BITS-1:0] w [wwtl_pkg::KEY_TEXT_WORDS];
      logic [wwtl_pkg::KEY_WORD_BITS-1:0] v;
      wwtl_pkg::csr_index_type            idx;
      for (int i = 0; i < wwtl_pkg::KEY_TEXT_BYTES; i++) begin
         w[i / 8][8 * (i % 8) +: 8] = (i < s.len()) ? s[i] : 8'($urandom);
      end
      for (int r = 0; r <= int'(wwtl_pkg::REG_KEY_FORM); r++) begin
         idx = wwtl_pkg::csr_index_type'(r);
         v   = {32'($urandom), 32'($urandom)};
         case (idx)
            wwtl_pkg::REG_KEY_LENGTH: v[wwtl_pkg::KEY_LEN_BITS-1:0] = len_field;
            wwtl_pkg::REG_KEY_FORM:   v[0] = quoted;
            default:                  v = w[r];
         endcase
         csr_addr   <= idx;
         csr_wdata  <= v;
         csr_tvalid <= 1'b1;
         do @(posedge clock); while (!(csr_tvalid && csr_tready));
         case (idx)
            wwtl_pkg::REG_KEY_LENGTH: key_len = v[wwtl_pkg::KEY_LEN_BITS-1:0];
            wwtl_pkg::REG_KEY_FORM:   key_quoted = v[0];
            default:                  key_word[r] = v;
         endcase
      end
      csr_tvalid <= 1'b0;
   endtask

   function automatic string random_word(input int lo, input int hi);
      string s;
      s = "";
      repeat ($urandom_range(lo, hi)) s = {s, ($urandom_range(0, 1) != 0) ? "a" : "b"};
      return s;
   endfunction

   function automatic string scramble_case(input string s);
      string t;
      t = s;
      for (int i = 0; i < t.len(); i++) begin
         if (t[i] >= "a" && t[i] <= "z" && $urandom_range(0, 1) != 0) t[i] = t[i] - 8'h20;
      end
      return t;
   endfunction

   function automatic void append_separator();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: text_buf.push_back(wwtl_pkg::CHAR_SPACE);
         5, 6:          text_buf.push_back(wwtl_pkg::CHAR_TAB);
         7, 8:          text_buf.push_back(wwtl_pkg::CHAR_NEWLINE);
         default:       text_buf.push_back(8'($urandom_range(0, 255)));
      endcase
   endfunction

   task automatic test_word_search();
      wait_idle();
      set_key("Cat", 3, 1'b0);
      append_text("cat CAT\tcAt\nconcat cat");
      send_buffer();
      wait_idle();
      set_key("a a", 3, 1'b0);
      append_text("a a a\taa a");
      send_buffer();
   endtask

   task automatic test_phrase_key();
      wait_idle();
      set_key("\"a b\"", 5, 1'b1);
      append_text("x A b a b");
      send_buffer();
      wait_idle();
      set_key("\"\"", 2, 1'b1);
      append_text("\"\" a");
      send_buffer();
   endtask

   task automatic test_degenerate_keys();
      wait_idle();
      set_key("a", 0, 1'b0);
      append_text("a a");
      send_buffer();
      wait_idle();
      set_key("a\nb", 3, 1'b0);
      append_text("a\nb a b");
      send_buffer();
      wait_idle();
      set_key("abcdefghijklmnopqrstuvwxyzABCDEF", 63, 1'b0);
      append_text("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdef ");
      send_buffer();
   endtask

   task automatic test_double_confirm();
      wait_idle();
      set_key("  ", 2, 1'b0);
      append_text("   ");
      send_buffer();
   endtask

   task automatic test_char_extremes();
      wait_idle();
      set_key("@[Z", 3, 1'b0);
      text_buf.push_back(8'h00);
      append_text(" `{z @[z ");
      text_buf.push_back(8'hFF);
      append_text(" @[Z");
      send_buffer();
   endtask

   task automatic test_random_text();
      string token;
      string key;
      int    len_field;
      bit    quoted;
      int    kind;
      int    stop_at;
      int    phase_end;
      stop_at = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < stop_at) begin
         wait_idle();
         req_gaps_on = $urandom_range(0, 3) != 0;
         rsp_gaps_on = $urandom_range(0, 3) != 0;
         kind   = $urandom_range(0, 9);
         quoted = 1'b0;
         if (kind < 5) begin
            token = random_word(1, 5);
            if (kind == 4) token = {token, " "};
            key       = token;
            len_field = key.len();
         end else if (kind < 8) begin
            token = {random_word(1, 3), " ", random_word(1, 3)};
            if ($urandom_range(0, 1) != 0) token = {token, "\t", random_word(1, 2)};
            key       = {"\"", token, "\""};
            len_field = key.len();
            quoted    = 1'b1;
         end else if (kind == 8) begin
            token     = random_word(32, 32);
            key       = token;
            len_field = ($urandom_range(0, 1) != 0) ? 32 : 63;
         end else begin
            token     = random_word(1, 3);
            key       = {"\"", token};
            quoted    = 1'($urandom_range(0, 1));
            len_field = quoted ? $urandom_range(0, 2) : 0;
         end
         set_key(key, wwtl_pkg::KEY_LEN_BITS'(len_field), quoted);
         phase_end = bytes_sent + $urandom_range(200, 320);
         while (bytes_sent < phase_end) begin
            repeat ($urandom_range(2, 16)) begin
               if ($urandom_range(0, 9) < 4) append_text(scramble_case(token));
               else append_text(random_word(1, 4));
               append_separator();
            end
            if ($urandom_range(0, 2) == 0) void'(text_buf.pop_back());
            send_buffer();
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      req_tvalid <= 1'b0;
      csr_tvalid <= 1'b0;
      csr_addr   <= wwtl_pkg::REG_KEY_TEXT_0;
      csr_wdata  <= '0;
      foreach (key_word[i]) key_word[i] = '0;
      key_len    = 1;
      key_quoted = 1'b0;
      restart_text();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_word_search();
      test_phrase_key();
      test_degenerate_keys();
      test_double_confirm();
      test_char_extremes();
      test_random_text();

      wait_idle();
      if (mismatches == 0 && expected_matches.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/wwtl_pkg.sv
hdl/wwtl_key_table.sv
hdl/whole_word_text_locator_core.sv
tb/sv/tb.sv
